### hw/rtl/frame_slot_status_tracker_macros.svh
// Assertion macros for the frame slot status tracker checker.
// Each macro expects clk in the scope where it is used; the first two also expect rst_n.
`ifndef FRAME_SLOT_STATUS_TRACKER_MACROS_SVH
`define FRAME_SLOT_STATUS_TRACKER_MACROS_SVH

// same-cycle implication, off while in reset
`define FSST_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame slot status tracker: check failed");

// next-cycle implication, off while in reset
`define FSST_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame slot status tracker: check failed");

// next-cycle implication, active through reset
`define FSST_ASSERT_RST(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("frame slot status tracker: check failed");

`endif

### hw/rtl/fsst_pkg.sv
// Shared types and constants for the frame slot status tracker.
// No dependencies; used by every RTL file of the block except fsst_ram.
`default_nettype none

package fsst_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int MODE_W     = 2;
  localparam int SLOT_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int INDEX_W    = 8;
  localparam int WKC_W      = 16;
  localparam int KIND_W     = 2;
  localparam int COUNT_W    = 16;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [KIND_W-1:0]   kind_t;

  localparam mode_t MODE_ALLOC = 2'd0;
  localparam mode_t MODE_SET   = 2'd1;
  localparam mode_t MODE_XMIT  = 2'd2;
  localparam mode_t MODE_POLL  = 2'd3;

  localparam status_t ST_EMPTY = 3'd0;
  localparam status_t ST_ALLOC = 3'd1;
  localparam status_t ST_SENT  = 3'd2;
  localparam status_t ST_RCVD  = 3'd3;
  localparam status_t ST_DONE  = 3'd4;

  localparam kind_t KIND_WKC   = 2'd0;
  localparam kind_t KIND_NONE  = 2'd1;
  localparam kind_t KIND_OTHER = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_MATCH,
    S_WKC
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ALLOC,
    OP_SET,
    OP_XMIT,
    OP_POLL_RCVD,
    OP_POLL_NONE,
    OP_POLL_OTHER,
    OP_POLL_SELF,
    OP_POLL_COUNT,
    OP_MATCH,
    OP_WKC_OUT
  } op_t;

  typedef struct packed {
    logic capture;
    logic rd_fidx;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  rcvd_hit;
    logic  present;
    logic  is_ecat;
    logic  self_hit;
    logic  out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/fsst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fsst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/fsst_datapath.sv
// Datapath: request registers, slot status file, round-robin allocator,
// frame counter, working-counter RAM and result register. Uses fsst_pkg, fsst_ram.
`default_nettype none

module fsst_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fsst_pkg::dp_cmd_t                  cmd,
  output fsst_pkg::dp_stat_t                 stat,
  input  logic [fsst_pkg::IN_DATA_W-1:0]     in_tdata,
  input  fsst_pkg::mode_t                    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fsst_pkg::OUT_DATA_W-1:0]    out_tdata,
  output fsst_pkg::kind_t                    out_tuser
);

  localparam int AW = fsst_pkg::SLOT_AW;

  fsst_pkg::mode_t                   mode_r;
  logic [fsst_pkg::SLOT_W-1:0]       slot_r;
  fsst_pkg::status_t                 new_status_r;
  logic                              send_ok_r;
  logic                              present_r;
  logic                              ecat_r;
  logic [fsst_pkg::INDEX_W-1:0]      fidx_r;
  logic [fsst_pkg::WKC_W-1:0]        fwkc_r;

  fsst_pkg::status_t                 status_r [fsst_pkg::SLOTS];
  logic [AW-1:0]                     last_r, last_nxt;
  logic [fsst_pkg::COUNT_W-1:0]      cnt_r, cnt_nxt;

  logic                              out_tvalid_r, out_tvalid_nxt;
  logic [fsst_pkg::SLOT_W-1:0]       given_r, given_nxt;
  fsst_pkg::kind_t                   kind_r, kind_nxt;
  logic [fsst_pkg::WKC_W-1:0]        wkc_r, wkc_nxt;
  logic                              failed_r, failed_nxt;
  logic [fsst_pkg::COUNT_W-1:0]      frames_r;

  logic                              slot_ok, fidx_ok, rd_ok;
  logic [AW-1:0]                     slot_a, fidx_a, rd_a;
  fsst_pkg::status_t                 rd_status;
  logic                              hi_found, lo_found;
  logic [AW-1:0]                     hi_pick, lo_pick, next_a, given;
  logic                              st_we, ram_we, load;
  logic [AW-1:0]                     st_wa, ram_wa;
  fsst_pkg::status_t                 st_wd;
  logic [fsst_pkg::WKC_W-1:0]        ram_rdata;

  assign slot_ok = ({5'd0, slot_r} < 9'(fsst_pkg::SLOTS));
  assign fidx_ok = ({1'b0, fidx_r} < 9'(fsst_pkg::SLOTS));
  assign slot_a  = AW'(slot_r);
  assign fidx_a  = AW'(fidx_r);
  assign rd_a    = cmd.rd_fidx ? fidx_a : slot_a;
  assign rd_ok   = cmd.rd_fidx ? fidx_ok : slot_ok;
  assign rd_status = rd_ok ? status_r[rd_a] : fsst_pkg::ST_EMPTY;

  assign stat.mode     = mode_r;
  assign stat.rcvd_hit = slot_ok && (rd_status == fsst_pkg::ST_RCVD);
  assign stat.present  = present_r;
  assign stat.is_ecat  = ecat_r;
  assign stat.self_hit = slot_ok && (fidx_r == {4'd0, slot_r});
  assign stat.out_busy = out_tvalid_r && !out_tready;

  // round-robin search: first empty slot above last_r, else lowest empty, else the slot after last_r
  always_comb begin
    hi_found = 1'b0;
    lo_found = 1'b0;
    hi_pick  = '0;
    lo_pick  = '0;
    for (int i = fsst_pkg::SLOTS - 1; i >= 0; i--) begin
      if (status_r[i] == fsst_pkg::ST_EMPTY) begin
        lo_found = 1'b1;
        lo_pick  = AW'(i);
        if (AW'(i) > last_r) begin
          hi_found = 1'b1;
          hi_pick  = AW'(i);
        end
      end
    end
    next_a = (last_r == AW'(fsst_pkg::SLOTS - 1)) ? '0 : last_r + 1'b1;
    given  = hi_found ? hi_pick : (lo_found ? lo_pick : next_a);
  end

  always_comb begin
    st_we      = 1'b0;
    st_wa      = slot_a;
    st_wd      = fsst_pkg::ST_EMPTY;
    ram_we     = 1'b0;
    ram_wa     = slot_a;
    last_nxt   = last_r;
    cnt_nxt    = cnt_r;
    load       = 1'b0;
    given_nxt  = '0;
    kind_nxt   = fsst_pkg::KIND_WKC;
    wkc_nxt    = '0;
    failed_nxt = 1'b0;
    case (cmd.op)
      fsst_pkg::OP_ALLOC: begin
        st_we     = 1'b1;
        st_wa     = given;
        st_wd     = fsst_pkg::ST_ALLOC;
        last_nxt  = given;
        load      = 1'b1;
        given_nxt = fsst_pkg::SLOT_W'(given);
      end
      fsst_pkg::OP_SET: begin
        st_we = slot_ok;
        st_wd = new_status_r;
        load  = 1'b1;
      end
      fsst_pkg::OP_XMIT: begin
        st_we      = slot_ok;
        st_wd      = send_ok_r ? fsst_pkg::ST_SENT : fsst_pkg::ST_EMPTY;
        failed_nxt = slot_ok && !send_ok_r;
        load       = 1'b1;
      end
      fsst_pkg::OP_POLL_RCVD: begin
        st_we = 1'b1;
        st_wd = fsst_pkg::ST_DONE;
      end
      fsst_pkg::OP_POLL_NONE: begin
        load     = 1'b1;
        kind_nxt = fsst_pkg::KIND_NONE;
      end
      fsst_pkg::OP_POLL_OTHER: begin
        load     = 1'b1;
        kind_nxt = fsst_pkg::KIND_OTHER;
      end
      fsst_pkg::OP_POLL_SELF: begin
        cnt_nxt = cnt_r + 1'b1;
        st_we   = 1'b1;
        st_wd   = fsst_pkg::ST_DONE;
        ram_we  = 1'b1;
        load    = 1'b1;
        wkc_nxt = fwkc_r;
      end
      fsst_pkg::OP_POLL_COUNT: begin
        cnt_nxt = cnt_r + 1'b1;
      end
      fsst_pkg::OP_MATCH: begin
        if (rd_ok && (rd_status == fsst_pkg::ST_SENT)) begin
          st_we  = 1'b1;
          st_wa  = fidx_a;
          st_wd  = fsst_pkg::ST_RCVD;
          ram_we = 1'b1;
          ram_wa = fidx_a;
        end
        load     = 1'b1;
        kind_nxt = fsst_pkg::KIND_OTHER;
      end
      fsst_pkg::OP_WKC_OUT: begin
        load    = 1'b1;
        wkc_nxt = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid_nxt = load || (out_tvalid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r       <= in_tuser;
      slot_r       <= in_tdata[3:0];
      new_status_r <= in_tdata[6:4];
      send_ok_r    <= in_tdata[7];
      present_r    <= in_tdata[8];
      ecat_r       <= in_tdata[9];
      fidx_r       <= in_tdata[17:10];
      fwkc_r       <= in_tdata[33:18];
    end
    if (load) begin
      given_r  <= given_nxt;
      kind_r   <= kind_nxt;
      wkc_r    <= wkc_nxt;
      failed_r <= failed_nxt;
      frames_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fsst_pkg::SLOTS; i++) begin
        status_r[i] <= fsst_pkg::ST_EMPTY;
      end
      last_r       <= '0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (st_we) begin
        status_r[st_wa] <= st_wd;
      end
      last_r       <= last_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  fsst_ram #(
    .WIDTH (fsst_pkg::WKC_W),
    .DEPTH (fsst_pkg::SLOTS)
  ) u_wkc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (fwkc_r),
    .raddr (slot_a),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'd0, frames_r, failed_r, wkc_r, given_r};
  assign out_tuser  = kind_r;

endmodule

`default_nettype wire

### hw/rtl/fsst_ctrl.sv
// Controller state machine: sequences each request through lookup,
// optional index match and stored working-counter read. Uses fsst_pkg.
`default_nettype none

module fsst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  fsst_pkg::dp_stat_t stat,
  output fsst_pkg::dp_cmd_t  cmd
);

  fsst_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.rd_fidx = 1'b0;
    cmd.op      = fsst_pkg::OP_NONE;
    case (state_r)
      fsst_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = fsst_pkg::S_LOOK;
        end
      end
      fsst_pkg::S_LOOK: begin
        // hold until the result register is free
        if (!stat.out_busy) begin
          state_nxt = fsst_pkg::S_IDLE;
          case (stat.mode)
            fsst_pkg::MODE_ALLOC: cmd.op = fsst_pkg::OP_ALLOC;
            fsst_pkg::MODE_SET:   cmd.op = fsst_pkg::OP_SET;
            fsst_pkg::MODE_XMIT:  cmd.op = fsst_pkg::OP_XMIT;
            fsst_pkg::MODE_POLL: begin
              if (stat.rcvd_hit) begin
                cmd.op    = fsst_pkg::OP_POLL_RCVD;
                state_nxt = fsst_pkg::S_WKC;
              end else if (!stat.present) begin
                cmd.op = fsst_pkg::OP_POLL_NONE;
              end else if (!stat.is_ecat) begin
                cmd.op = fsst_pkg::OP_POLL_OTHER;
              end else if (stat.self_hit) begin
                cmd.op = fsst_pkg::OP_POLL_SELF;
              end else begin
                cmd.op    = fsst_pkg::OP_POLL_COUNT;
                state_nxt = fsst_pkg::S_MATCH;
              end
            end
            default: cmd.op = fsst_pkg::OP_NONE;
          endcase
        end
      end
      fsst_pkg::S_MATCH: begin
        cmd.rd_fidx = 1'b1;
        cmd.op      = fsst_pkg::OP_MATCH;
        state_nxt   = fsst_pkg::S_IDLE;
      end
      fsst_pkg::S_WKC: begin
        cmd.op    = fsst_pkg::OP_WKC_OUT;
        state_nxt = fsst_pkg::S_IDLE;
      end
      default: state_nxt = fsst_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/frame_slot_status_tracker.sv
// Frame slot status tracker: allocates, updates and polls frame slots
// one request at a time, with one result per request. Each request passes
// through accept and then a slot status lookup that also updates state and
// loads the result; a poll adds a further step when it returns a stored
// working counter (registered read of the working-counter RAM) or offers the
// frame to another waiting slot (a second status lookup at the frame's index).
// A finished result waits in the output register while the next request is
// taken. The status file clears at reset; the working-counter RAM is not
// cleared. Uses fsst_pkg, fsst_ctrl, fsst_datapath.
`default_nettype none

module frame_slot_status_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // slot[3:0] new_status[6:4] send_ok[7] frame_present[8] frame_is_ecat[9]
  // frame_index[17:10] frame_wkc[33:18] frame_source_word[49:34]
  input  logic [fsst_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  fsst_pkg::mode_t                 in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // given_slot[3:0] working_count[19:4] send_failed[20] frames_seen[36:21]
  output logic [fsst_pkg::OUT_DATA_W-1:0] out_tdata,
  // reply_kind[1:0]
  output fsst_pkg::kind_t                 out_tuser
);

  fsst_pkg::dp_cmd_t  cmd;
  fsst_pkg::dp_stat_t stat;

  fsst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fsst_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

### hw/rtl/fsst_checker.sv
// Port-level checker for the frame slot status tracker, bound to the top.
// Uses fsst_pkg and frame_slot_status_tracker_macros.svh.
`default_nettype none

`include "frame_slot_status_tracker_macros.svh"

module fsst_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [fsst_pkg::IN_DATA_W-1:0]  in_tdata,
  input wire fsst_pkg::mode_t                 in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [fsst_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire fsst_pkg::kind_t                 out_tuser
);

  `FSST_ASSERT_RST(a_rst_no_result, !rst_n, !out_tvalid)
  `FSST_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `FSST_ASSERT_NXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)
  `FSST_ASSERT_IMP(a_wkc_only_valid, out_tvalid && (out_tuser != fsst_pkg::KIND_WKC), out_tdata[19:4] == 16'd0)

endmodule

bind frame_slot_status_tracker fsst_checker u_fsst_checker (.*);

`default_nettype wire

### verif/frame_slot_status_tracker_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for frame_slot_status_tracker: directed and random slot
// requests, with replies checked against an in-bench slot table predictor.
// Depends on fsst_pkg and the block's RTL.

module frame_slot_status_tracker_tb;
  import fsst_pkg::*;

  localparam int RANDOM_REQUESTS = 850;

  typedef struct {
    mode_t              mode;
    logic [SLOT_W-1:0]  slot;
    status_t            new_status;
    logic               send_ok;
    logic               present;
    logic               is_ecat;
    logic [INDEX_W-1:0] index;
    logic [WKC_W-1:0]   wkc;
    logic [15:0]        source;
  } slot_request_t;

  typedef struct {
    logic [SLOT_W-1:0]  given;
    kind_t              kind;
    logic [WKC_W-1:0]   wkc;
    logic               failed;
    logic [COUNT_W-1:0] seen;
  } slot_reply_t;

  class slot_reply_board;
    status_t            slot_state[SLOTS];
    logic [WKC_W-1:0]   wkc_store[SLOTS];
    logic [15:0]        source_store[SLOTS];
    bit                 wkc_known[SLOTS];
    int                 last_handed;
    logic [COUNT_W-1:0] ecat_seen;
    slot_reply_t        expected_replies[$];
    int                 errors;
    int                 requests;
    int                 replies;
    int                 wkc_returns;
    int                 full_allocs;

    function new();
      foreach (slot_state[i]) begin
        slot_state[i]   = ST_EMPTY;
        wkc_store[i]    = '0;
        source_store[i] = '0;
        wkc_known[i]    = 1'b0;
      end
      last_handed = 0;
      ecat_seen   = '0;
      errors      = 0;
      requests    = 0;
      replies     = 0;
      wkc_returns = 0;
      full_allocs = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function int step_slot(int s);
      return (s + 1 >= SLOTS) ? 0 : s + 1;
    endfunction

    function void note_request(slot_request_t r);
      slot_reply_t e;
      int s;
      int n;
      int f;
      e = '{given: '0, kind: KIND_WKC, wkc: '0, failed: 1'b0, seen: '0};
      s = int'(r.slot);
      f = int'(r.index);
      case (r.mode)
        MODE_ALLOC: begin
          s = step_slot(last_handed);
          n = 0;
          while (slot_state[s] != ST_EMPTY && n < SLOTS) begin
            s = step_slot(s);
            n++;
          end
          if (n == SLOTS) full_allocs++;
          slot_state[s] = ST_ALLOC;
          last_handed   = s;
          e.given       = SLOT_W'(s);
        end
        MODE_SET: begin
          if (s < SLOTS) slot_state[s] = r.new_status;
        end
        MODE_XMIT: begin
          if (s < SLOTS) begin
            if (r.send_ok) begin
              slot_state[s] = ST_SENT;
            end else begin
              slot_state[s] = ST_EMPTY;
              e.failed      = 1'b1;
            end
          end
        end
        default: begin
          if (s < SLOTS && slot_state[s] == ST_RCVD) begin
            e.wkc         = wkc_store[s];
            slot_state[s] = ST_DONE;
          end else if (!r.present) begin
            e.kind = KIND_NONE;
          end else if (!r.is_ecat) begin
            e.kind = KIND_OTHER;
          end else begin
            ecat_seen++;
            if (f == s && s < SLOTS) begin
              wkc_store[s]    = r.wkc;
              source_store[s] = r.source;
              wkc_known[s]    = 1'b1;
              slot_state[s]   = ST_DONE;
              e.wkc           = r.wkc;
            end else begin
              e.kind = KIND_OTHER;
              if (f < SLOTS && slot_state[f] == ST_SENT) begin
                wkc_store[f]    = r.wkc;
                source_store[f] = r.source;
                wkc_known[f]    = 1'b1;
                slot_state[f]   = ST_RCVD;
              end
            end
          end
          if (e.kind == KIND_WKC) wkc_returns++;
        end
      endcase
      e.seen = ecat_seen;
      requests++;
      expected_replies.push_back(e);
    endfunction

    function void check_reply(logic [OUT_DATA_W-1:0] data, kind_t kind);
      slot_reply_t e;
      replies++;
      if (expected_replies.size() == 0) begin
        $error("reply with no request outstanding: data %h, reply_kind %0d", data, kind);
        errors++;
        return;
      end
      e = expected_replies.pop_front();
      if (data[3:0] !== e.given) begin
        $error("given_slot: expected %0d, got %0d", e.given, data[3:0]);
        errors++;
      end
      if (kind !== e.kind) begin
        $error("reply_kind: expected %0d, got %0d", e.kind, kind);
        errors++;
      end
      if (data[19:4] !== e.wkc) begin
        $error("working_count: expected %0d, got %0d", e.wkc, data[19:4]);
        errors++;
      end
      if (data[20] !== e.failed) begin
        $error("send_failed: expected %0d, got %0d", e.failed, data[20]);
        errors++;
      end
      if (data[36:21] !== e.seen) begin
        $error("frames_seen: expected %0d, got %0d", e.seen, data[36:21]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  mode_t                 in_tuser   = MODE_ALLOC;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  kind_t                 out_tuser;

  slot_reply_board sb;
  bit              steady     = 1'b0;
  int              stall_left = 0;

  frame_slot_status_tracker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  function automatic int idle_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic slot_request_t noise_request();
    slot_request_t r;
    r.mode       = mode_t'($urandom_range(0, 3));
    r.slot       = SLOT_W'($urandom_range(0, SLOTS - 1));
    r.new_status = status_t'($urandom_range(0, 7));
    r.send_ok    = 1'($urandom_range(0, 1));
    r.present    = ($urandom_range(0, 3) != 0);
    r.is_ecat    = ($urandom_range(0, 3) != 0);
    r.index      = $urandom_range(0, 1) ? INDEX_W'($urandom_range(0, SLOTS - 1))
                                        : INDEX_W'($urandom_range(0, 255));
    r.wkc        = WKC_W'($urandom_range(0, 65535));
    r.source     = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  function automatic slot_request_t request_of(mode_t m, int slot, status_t st, bit ok,
                                               bit pres, bit ecat, int idx, int wkc,
                                               int src);
    slot_request_t r;
    r.mode       = m;
    r.slot       = SLOT_W'(slot);
    r.new_status = st;
    r.send_ok    = ok;
    r.present    = pres;
    r.is_ecat    = ecat;
    r.index      = INDEX_W'(idx);
    r.wkc        = WKC_W'(wkc);
    r.source     = 16'(src);
    return r;
  endfunction

  task automatic issue(slot_request_t r);
    int gap;
    // keep set-status from marking a never-filled slot as received
    if (r.mode == MODE_SET && r.new_status == ST_RCVD && !sb.wkc_known[r.slot])
      r.new_status = ST_DONE;
    gap = steady ? 0 : idle_span();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= r.mode;
    in_tdata  <= {6'b0, r.source, r.wkc, r.index, r.is_ecat, r.present, r.send_ok,
                  r.new_status, r.slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_lifecycle();
    slot_request_t r;
    int s;
    r = noise_request();
    r.mode = MODE_ALLOC;
    issue(r);
    s = sb.last_handed;
    r = noise_request();
    r.mode    = MODE_XMIT;
    r.slot    = SLOT_W'(s);
    r.send_ok = ($urandom_range(0, 7) != 0);
    issue(r);
    if ($urandom_range(0, 3) == 0) issue(noise_request());
    r = noise_request();
    r.mode    = MODE_POLL;
    r.present = 1'b1;
    r.is_ecat = 1'b1;
    r.index   = INDEX_W'(s);
    if ($urandom_range(0, 1)) begin
      r.slot = SLOT_W'(s);
      issue(r);
    end else begin
      r.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
      issue(r);
      r = noise_request();
      r.mode = MODE_POLL;
      r.slot = SLOT_W'(s);
      issue(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tdata, out_tuser);
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) stall_left = idle_span();
    end
  end

  initial begin
    #20_000_000;
    $display("frame_slot_status_tracker regression: fail");
    $finish;
  end

  initial begin
    slot_request_t r;
    int base;
    int roll;
    bit paused;
    sb     = new();
    paused = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    issue(request_of(MODE_POLL,  0, ST_EMPTY, 0, 0, 0, 0,   0,      0));
    issue(request_of(MODE_POLL,  0, ST_EMPTY, 0, 1, 0, 0,   16'h5a5a, 16'ha5a5));
    issue(request_of(MODE_ALLOC, 0, ST_EMPTY, 0, 0, 0, 0,   0,      0));
    issue(request_of(MODE_ALLOC, 0, ST_EMPTY, 0, 0, 0, 0,   0,      0));
    issue(request_of(MODE_XMIT,  1, ST_EMPTY, 1, 0, 0, 0,   0,      0));
    issue(request_of(MODE_XMIT,  2, ST_EMPTY, 0, 0, 0, 0,   0,      0));
    issue(request_of(MODE_POLL,  5, ST_EMPTY, 0, 1, 1, 1,   16'hffff, 16'hffff));
    issue(request_of(MODE_POLL,  1, ST_EMPTY, 0, 1, 1, 1,   0,      0));
    issue(request_of(MODE_POLL,  3, ST_EMPTY, 0, 1, 1, 3,   0,      0));
    issue(request_of(MODE_POLL,  0, ST_EMPTY, 0, 1, 1, 255, 16'h8000, 16'h0001));
    issue(request_of(MODE_SET,  15, status_t'(7), 0, 0, 0, 0, 0, 0));
    issue(request_of(MODE_SET,   6, status_t'(5), 0, 0, 0, 0, 0, 0));
    issue(request_of(MODE_POLL, 15, ST_EMPTY, 0, 1, 1, 200, 1234,   4321));
    issue(request_of(MODE_ALLOC, 0, ST_EMPTY, 0, 0, 0, 0,   0,      0));
    issue(request_of(MODE_XMIT, 15, ST_EMPTY, 1, 0, 0, 0,   0,      0));
    issue(request_of(MODE_POLL,  0, ST_EMPTY, 0, 1, 1, 15,  16'h0f0f, 16'hf0f0));
    issue(request_of(MODE_SET,  15, ST_RCVD,  0, 0, 0, 0,   0,      0));
    issue(request_of(MODE_POLL, 15, ST_EMPTY, 0, 0, 0, 0,   0,      0));
    issue(request_of(MODE_SET,   0, ST_DONE,  0, 0, 0, 0,   0,      0));
    issue(request_of(MODE_XMIT,  0, ST_EMPTY, 0, 0, 0, 0,   0,      0));
    issue(request_of(MODE_POLL, 15, ST_EMPTY, 0, 1, 1, 15,  16'h7fff, 16'h1234));

    base = sb.requests;
    while (sb.requests < base + RANDOM_REQUESTS) begin
      if ($urandom_range(0, 39) == 0) steady = ~steady;
      if (!paused && sb.requests >= base + RANDOM_REQUESTS / 2) begin
        drain();
        paused = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        run_lifecycle();
      end else if (roll < 70) begin
        r = noise_request();
        if ($urandom_range(0, 1)) begin
          r.mode       = MODE_SET;
          r.new_status = ST_EMPTY;
        end else begin
          r.mode    = MODE_XMIT;
          r.send_ok = 1'b0;
        end
        issue(r);
      end else begin
        issue(noise_request());
      end
    end

    drain();
    repeat (12) @(posedge clk);
    $display("covered %0d requests and %0d replies: %0d working counters returned,",
             sb.requests, sb.replies, sb.wkc_returns);
    $display("%0d allocations from a full table, %0d EtherCAT frames",
             sb.full_allocs, sb.ecat_seen);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("frame_slot_status_tracker regression: pass");
    else
      $display("frame_slot_status_tracker regression: fail");
    $finish;
  end

endmodule
